// ----- sv/button_edge_state_table_top_assert.svh -----
// Assertion macros used by the button edge state table controller.
`ifndef BUTTON_EDGE_STATE_TABLE_TOP_ASSERT_SVH
`define BUTTON_EDGE_STATE_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BETT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("bett assertion failed");
`define BETT_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("bett assertion failed");
`else
`define BETT_ASSERT(label, prop)
`define BETT_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ----- sv/bett_pkg.sv -----
// Types and constants of the button edge state table.
package bett_pkg;

   localparam int IDX_W = 10;
   localparam int OP_W  = 3;

   localparam logic [OP_W-1:0] OP_PRESS       = 3'd0;
   localparam logic [OP_W-1:0] OP_RELEASE     = 3'd1;
   localparam logic [OP_W-1:0] OP_FRAME       = 3'd2;
   localparam logic [OP_W-1:0] OP_QUERY       = 3'd3;
   localparam logic [OP_W-1:0] OP_CONSUME     = 3'd4;
   localparam logic [OP_W-1:0] OP_CONSUME_ALL = 3'd5;

   typedef enum logic [1:0] {
      CODE_RELEASED      = 2'd0,
      CODE_JUST_PRESSED  = 2'd1,
      CODE_PRESSED       = 2'd2,
      CODE_JUST_RELEASED = 2'd3
   } code_type;

   typedef struct packed {
      logic     pending;
      code_type code;
   } entry_type;

   typedef struct packed {
      logic load;
      logic clear_wr;
      logic sweep_rd;
      logic lookup_rd;
      logic modify;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic new_sweep;
      logic last;
      logic rsp_free;
   } sts_type;

endpackage

// ----- sv/button_edge_state_table_top.sv -----
// Top level of the button edge state table.
// Usage: one request transaction on req_* yields exactly one result on rsp_*.
// req_tdata carries the button index, req_tuser the operation and repeat flag.
// Press, release, query and consume one go from acceptance through the lookup,
// modify and done states; done publishes the result once the output register is free.
// Frame tick and consume all first walk the whole table through the
// single-port-read entry memory, one entry a cycle, then drain and do the same.
// One request is in flight at a time; req_tready is high only while the block is
// idle.
// After reset a clearing pass writes every entry to released, one a cycle;
// req_tready stays low until it ends.
// The result sits in an output register; a request is still accepted while
// it waits, and the next result is held back until rsp_tready takes the old.
module button_edge_state_table_top import bett_pkg::*; #(
   parameter int TABLE_ENTRIES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [9:0] button_index, zero above
   input  logic [3:0]  req_tuser,  // [2:0] operation, [3] is_repeat
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // [1:0] entry_state, [2] held, [3] rising,
                                   // [4] falling, [5] index_fault, zero above
);

   cmd_type cmd;
   sts_type sts;

   bett_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bett_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ----- sv/bett_ctrl.sv -----
// Controller state machine of the button edge state table.
`include "button_edge_state_table_top_assert.svh"

module bett_ctrl import bett_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_LOOKUP,
      ST_MODIFY,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sts.new_sweep ? ST_SWEEP : ST_LOOKUP;
            end
         end
         ST_SWEEP: begin
            cmd.sweep_rd = 1'b1;
            if (sts.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup_rd = 1'b1;
            state_in      = ST_MODIFY;
         end
         ST_MODIFY: begin
            cmd.modify = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `BETT_ASSERT_ALWAYS(a_reset_clears, reset |=> state_ff == ST_CLEAR && !req_tready)
   `BETT_ASSERT(a_lookup_then_modify, state_ff == ST_LOOKUP |=> state_ff == ST_MODIFY)
   `BETT_ASSERT(a_sweep_ends, state_ff == ST_SWEEP && sts.last |=> state_ff == ST_DRAIN)
   `BETT_ASSERT(a_drain_after_sweep, state_ff == ST_DRAIN |-> $past(state_ff) == ST_SWEEP)
   `BETT_ASSERT(a_one_in_flight, cmd.load |=> !req_tready)

endmodule

// ----- sv/bett_datapath.sv -----
// Datapath of the button edge state table: entry memory, sweep pipe, result register.
module bett_datapath import bett_pkg::*; #(
   parameter int TABLE_ENTRIES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] req_tdata,
   input  logic [3:0]  req_tuser,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [7:0]  rsp_tdata,
   input  cmd_type     cmd,
   output sts_type     sts
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [AW-1:0]  LAST_ADDR = AW'(TABLE_ENTRIES - 1);
   localparam logic [IDX_W:0] ENTRIES_W = (IDX_W + 1)'(TABLE_ENTRIES);

   entry_type mem [TABLE_ENTRIES];

   logic [OP_W-1:0]  op_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             rpt_ff;
   logic [AW-1:0]    cnt_ff, cnt_in;
   entry_type        rd_ff;
   logic             sw_v_ff;
   logic [AW-1:0]    sw_addr_ff;
   code_type         res_code_ff;
   logic             res_fault_ff;
   logic             rsp_valid_ff;
   code_type         rsp_code_ff;
   logic             rsp_fault_ff;

   logic          fault;
   logic [AW-1:0] lookup_addr;
   entry_type     sweep_entry;
   entry_type     mod_entry;
   logic          mod_we;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   assign fault       = ({1'b0, idx_ff} >= ENTRIES_W);
   assign lookup_addr = idx_ff[AW-1:0];

   always_comb begin
      sts.new_sweep = req_tuser[OP_W-1:0] inside {OP_FRAME, OP_CONSUME_ALL};
      sts.last      = (cnt_ff == LAST_ADDR);
      sts.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   // per-entry update of a sweep
   always_comb begin
      sweep_entry = rd_ff;
      if (op_ff == OP_CONSUME_ALL) begin
         sweep_entry.code = CODE_RELEASED;
      end else if (rd_ff.pending) begin
         sweep_entry.pending = 1'b0;
         sweep_entry.code    = CODE_JUST_RELEASED;
      end else if (rd_ff.code == CODE_JUST_RELEASED) begin
         sweep_entry.code = CODE_RELEASED;
      end else if (rd_ff.code == CODE_JUST_PRESSED) begin
         sweep_entry.code = CODE_PRESSED;
      end
   end

   always_comb begin
      mod_entry = rd_ff;
      mod_we    = 1'b0;
      case (op_ff)
         OP_PRESS: begin
            if (!fault && !rpt_ff) begin
               mod_we            = 1'b1;
               mod_entry.pending = 1'b0;
               mod_entry.code    = CODE_JUST_PRESSED;
            end
         end
         OP_RELEASE: begin
            if (!fault && !rpt_ff) begin
               mod_we = 1'b1;
               if (rd_ff.code == CODE_JUST_PRESSED) begin
                  mod_entry.pending = 1'b1;
               end else begin
                  mod_entry.pending = 1'b0;
                  mod_entry.code    = CODE_JUST_RELEASED;
               end
            end
         end
         OP_CONSUME: begin
            if (!fault) begin
               mod_we         = 1'b1;
               mod_entry.code = CODE_RELEASED;
            end
         end
         default: begin
            mod_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = lookup_addr;
      wr_data = mod_entry;
      if (cmd.clear_wr) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff;
         wr_data = '0;
      end else if (sw_v_ff) begin
         wr_en   = 1'b1;
         wr_addr = sw_addr_ff;
         wr_data = sweep_entry;
      end else if (cmd.modify && mod_we) begin
         wr_en = 1'b1;
      end
   end

   assign rd_en   = cmd.sweep_rd || cmd.lookup_rd;
   assign rd_addr = cmd.sweep_rd ? cnt_ff : lookup_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clear_wr || cmd.sweep_rd) begin
         cnt_in = (cnt_ff == LAST_ADDR) ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         sw_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         sw_v_ff <= cmd.sweep_rd;
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sw_addr_ff <= cnt_ff;
      if (cmd.load) begin
         op_ff  <= req_tuser[OP_W-1:0];
         rpt_ff <= req_tuser[OP_W];
         idx_ff <= req_tdata[IDX_W-1:0];
      end
      if (cmd.modify) begin
         res_code_ff  <= fault ? CODE_RELEASED : mod_entry.code;
         res_fault_ff <= fault;
      end
      if (cmd.publish) begin
         rsp_code_ff  <= res_code_ff;
         rsp_fault_ff <= res_fault_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp_fault_ff,
                        rsp_code_ff == CODE_JUST_RELEASED,
                        rsp_code_ff == CODE_JUST_PRESSED,
                        rsp_code_ff == CODE_JUST_PRESSED || rsp_code_ff == CODE_PRESSED,
                        rsp_code_ff};

endmodule

// ----- test/button_edge_state_table_top_tb.sv -----
// Self-checking stream testbench of the button edge state table: directed rows, then random keys.
module button_edge_state_table_top_tb;
   import bett_pkg::*;

   localparam int ENTRIES     = 512;
   localparam int RANDOM_KEYS = 1150;
   localparam int CALM_KEYS   = 150;
   localparam int DRAIN       = 32;
   localparam int LIMIT       = 3_000_000;
   localparam int PLAN_ROWS   = 25;

   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

   typedef struct packed {
      logic [1:0] spare;
      logic       fault;
      logic       falling;
      logic       rising;
      logic       held;
      code_type   state;
   } status_type;

   typedef struct packed {
      logic       pinned;
      status_type value;
   } pin_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
      logic             rep;
      logic             pinned;
      status_type       value;
   } row_type;

   localparam status_type ST_IDLE  = '{2'b0, 1'b0, 1'b0, 1'b0, 1'b0, CODE_RELEASED};
   localparam status_type ST_FAULT = '{2'b0, 1'b1, 1'b0, 1'b0, 1'b0, CODE_RELEASED};
   localparam status_type ST_FRESH = '{2'b0, 1'b0, 1'b0, 1'b1, 1'b1, CODE_JUST_PRESSED};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;  // [9:0] button_index, zero above
   logic [3:0]  req_tuser  = '0;  // [2:0] operation, [3] is_repeat
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [1:0] entry_state, [2] held, [3] rising,
                                  // [4] falling, [5] index_fault, zero above

   code_type key_code [ENTRIES];
   logic     key_pend [ENTRIES];

   status_type expected_status_q [$];
   pin_type    pin_q [$];
   row_type    plan [PLAN_ROWS];
   int         pool [6];

   int   keys_sent    = 0;
   int   results_seen = 0;
   int   mismatches   = 0;
   int   cycles       = 0;
   int   stall_left   = 0;
   logic calm         = 1'b0;

   button_edge_state_table_top #(.TABLE_ENTRIES(ENTRIES)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic status_type advance_table(logic [OP_W-1:0] op,
                                                logic [IDX_W-1:0] idx, logic rep);
      status_type res;
      logic       fault;
      int         i;
      res   = ST_IDLE;
      fault = (idx >= ENTRIES);
      case (op)
         OP_PRESS: begin
            if (!fault && !rep) begin
               key_code[idx] = CODE_JUST_PRESSED;
               key_pend[idx] = 1'b0;
            end
         end
         OP_RELEASE: begin
            if (!fault && !rep) begin
               if (key_code[idx] == CODE_JUST_PRESSED) begin
                  key_pend[idx] = 1'b1;
               end else begin
                  key_code[idx] = CODE_JUST_RELEASED;
                  key_pend[idx] = 1'b0;
               end
            end
         end
         OP_FRAME: begin
            for (i = 0; i < ENTRIES; i++) begin
               if (key_pend[i]) begin
                  key_code[i] = CODE_JUST_RELEASED;
                  key_pend[i] = 1'b0;
               end else if (key_code[i] == CODE_JUST_RELEASED) begin
                  key_code[i] = CODE_RELEASED;
               end else if (key_code[i] == CODE_JUST_PRESSED) begin
                  key_code[i] = CODE_PRESSED;
               end
            end
         end
         OP_CONSUME: begin
            if (!fault) key_code[idx] = CODE_RELEASED;
         end
         OP_CONSUME_ALL: begin
            for (i = 0; i < ENTRIES; i++) key_code[i] = CODE_RELEASED;
         end
         default: ;
      endcase
      if (fault) begin
         res.fault = 1'b1;
      end else begin
         res.state   = key_code[idx];
         res.held    = (res.state == CODE_PRESSED) || (res.state == CODE_JUST_PRESSED);
         res.rising  = (res.state == CODE_JUST_PRESSED);
         res.falling = (res.state == CODE_JUST_RELEASED);
      end
      return res;
   endfunction

   task automatic note_mismatch(string why, status_type want, status_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at result %0d (%s): ", results_seen, why,
                  "expected state %0d held %b rising %b falling %b fault %b spare %b, ",
                  want.state, want.held, want.rising, want.falling, want.fault, want.spare,
                  "got state %0d held %b rising %b falling %b fault %b spare %b",
                  got.state, got.held, got.rising, got.falling, got.fault, got.spare);
   endtask

   always @(posedge clock) begin : watch
      status_type want;
      status_type got;
      pin_type    pin;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            results_seen++;
            if (expected_status_q.size() == 0) begin
               note_mismatch("no transaction pending", ST_IDLE, got);
            end else begin
               want = expected_status_q.pop_front();
               if (got !== want) note_mismatch("field", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            pin  = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
            want = advance_table(req_tuser[2:0], req_tdata[IDX_W-1:0], req_tuser[3]);
            if (pin.pinned) want = pin.value;
            expected_status_q.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_key(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, logic rep,
                           logic pinned, status_type value);
      pin_q.push_back('{pinned, value});
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, idx};
      req_tuser  <= {rep, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      keys_sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int               n;
      int               r;
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
      logic             rep;

      plan = '{
         '{OP_QUERY,       10'd0,    1'b0, 1'b1, ST_IDLE},
         '{OP_QUERY,       10'd511,  1'b0, 1'b1, ST_IDLE},
         '{OP_QUERY,       10'd512,  1'b0, 1'b1, ST_FAULT},
         '{OP_QUERY,       10'd1023, 1'b0, 1'b1, ST_FAULT},
         '{OP_PRESS,       10'd0,    1'b0, 1'b1, ST_FRESH},
         '{OP_PRESS,       10'd1023, 1'b0, 1'b1, ST_FAULT},
         '{OP_RELEASE,     10'd0,    1'b0, 1'b0, ST_IDLE},
         '{OP_FRAME,       10'd0,    1'b0, 1'b0, ST_IDLE},
         '{OP_PRESS,       10'd511,  1'b1, 1'b1, ST_IDLE},
         '{OP_PRESS,       10'd511,  1'b0, 1'b1, ST_FRESH},
         '{OP_FRAME,       10'd511,  1'b0, 1'b0, ST_IDLE},
         '{OP_RELEASE,     10'd511,  1'b1, 1'b0, ST_IDLE},
         '{OP_RELEASE,     10'd511,  1'b0, 1'b0, ST_IDLE},
         '{OP_FRAME,       10'd511,  1'b0, 1'b0, ST_IDLE},
         '{OP_PRESS,       10'd5,    1'b0, 1'b1, ST_FRESH},
         '{OP_RELEASE,     10'd5,    1'b0, 1'b0, ST_IDLE},
         '{OP_CONSUME,     10'd5,    1'b0, 1'b1, ST_IDLE},
         '{OP_FRAME,       10'd5,    1'b0, 1'b0, ST_IDLE},
         '{OP_PRESS,       10'd5,    1'b0, 1'b1, ST_FRESH},
         '{OP_RELEASE,     10'd5,    1'b0, 1'b0, ST_IDLE},
         '{OP_PRESS,       10'd5,    1'b0, 1'b1, ST_FRESH},
         '{OP_CONSUME_ALL, 10'd5,    1'b0, 1'b1, ST_IDLE},
         '{OP_SPARE6,      10'd5,    1'b0, 1'b0, ST_IDLE},
         '{OP_SPARE7,      10'd1023, 1'b1, 1'b1, ST_FAULT},
         '{OP_CONSUME,     10'd700,  1'b0, 1'b1, ST_FAULT}
      };
      for (n = 0; n < ENTRIES; n++) begin
         key_code[n] = CODE_RELEASED;
         key_pend[n] = 1'b0;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < PLAN_ROWS; n++)
         send_key(plan[n].op, plan[n].idx, plan[n].rep, plan[n].pinned, plan[n].value);

      for (n = 0; n < RANDOM_KEYS; n++) begin
         if (n % 64 == 0)
            foreach (pool[k]) pool[k] = $urandom_range(0, ENTRIES - 1);
         if (n == RANDOM_KEYS / 2) begin
            req_tvalid <= 1'b0;
            while (results_seen != keys_sent) @(posedge clock);
         end
         if (n == RANDOM_KEYS - CALM_KEYS) calm = 1'b1;

         r = $urandom_range(0, 99);
         if (r < 30)      op = OP_PRESS;
         else if (r < 58) op = OP_RELEASE;
         else if (r < 70) op = OP_FRAME;
         else if (r < 80) op = OP_QUERY;
         else if (r < 88) op = OP_CONSUME;
         else if (r < 92) op = OP_CONSUME_ALL;
         else if (r < 96) op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
         else             op = OP_QUERY;

         r = $urandom_range(0, 9);
         if (r < 8) begin
            idx = IDX_W'(pool[$urandom_range(0, 5)]);
         end else if (r < 9) begin
            idx = IDX_W'($urandom_range(0, 1023));
         end else begin
            case ($urandom_range(0, 3))
               0:       idx = 10'd0;
               1:       idx = IDX_W'(ENTRIES - 1);
               2:       idx = IDX_W'(ENTRIES);
               default: idx = 10'd1023;
            endcase
         end
         rep = ($urandom_range(0, 6) == 0);

         send_key(op, idx, rep, 1'b0, ST_IDLE);
      end

      req_tvalid <= 1'b0;
      while (results_seen != keys_sent) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (mismatches == 0 && expected_status_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
